FILE: hw/rtl/irpr_pkg.sv
// irpr_pkg: shared types for the ir pulse-ratio decoder
// holds the controller/datapath command and status structs and the result record
// no dependencies
package irpr_pkg;

  // result kinds
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // line level codes
  localparam logic LEVEL_ON  = 1'b1;
  localparam logic LEVEL_OFF = 1'b0;

  // output mode register values
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_RUNS  = 1'b1;

  // widths of the result fields
  localparam int WidthBits = 16;
  localparam int CodeBits  = 32;
  localparam int TdataBits = 64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take a new input word
    logic step;     // process one sample
    logic trail;    // push the trailing run into the pending slot, then clear
    logic frame;    // emit the decoded frame, then clear
    logic clear;    // clear the decode state
    logic flush;    // emit the pending run as the final result
  } irpr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mode;         // current output mode
    logic trans;        // the current sample ends a run
    logic pend_valid;   // a run report waits in the pending slot
    logic out_busy;     // output register holds an untaken result
    logic last_sample;  // the current sample is the last of the word
    logic last_word;    // the word in work closes a capture
    logic run_one;      // the open run is exactly one sample long
  } irpr_sts_t;

  // one result record before packing
  typedef struct packed {
    logic                 kind;
    logic                 level;
    logic [WidthBits-1:0] width;
    logic [CodeBits-1:0]  code;
    logic                 last;
  } irpr_res_t;

endpackage

FILE: hw/rtl/irpr_datapath.sv
// irpr_datapath: sample shifter, run counters, bit decoder, pending slot and output register
// depends on irpr_pkg; driven by irpr_ctrl through irpr_cmd_t
module irpr_datapath #(
  parameter int SAMPLES_PER_WORD = 32,
  parameter int RUN_COUNT_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irpr_pkg::irpr_cmd_t cmd_i,
  output irpr_pkg::irpr_sts_t sts_o,
  input  logic [31:0]       word_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  logic              cfg_mode_i,
  input  logic              out_take_i,
  output logic              out_valid_o,
  output irpr_pkg::irpr_res_t out_res_o
);
  import irpr_pkg::*;

  localparam int CntBits = $clog2(SAMPLES_PER_WORD);
  localparam int RunExt  = RUN_COUNT_BITS + WidthBits;
  localparam int ProdW   = RUN_COUNT_BITS + 3;

  logic [SAMPLES_PER_WORD-1:0] word_q, word_d;
  logic [CntBits-1:0]          cnt_q, cnt_d;
  logic                        last_q, last_d;
  logic                        mode_q, mode_d;
  logic                        level_q, level_d;
  logic [RUN_COUNT_BITS-1:0]   run_q, run_d;
  logic [RUN_COUNT_BITS-1:0]   mark_q, mark_d;
  logic [CodeBits-1:0]         code_q, code_d;
  logic                        pend_valid_q, pend_valid_d;
  logic                        pend_level_q, pend_level_d;
  logic [WidthBits-1:0]        pend_width_q, pend_width_d;
  logic                        out_valid_q, out_valid_d;
  irpr_res_t                   out_q, out_d;

  logic                  sample;
  logic                  trans;
  logic [RunExt-1:0]     run_ext;
  logic [WidthBits-1:0]  run_sat;
  logic [ProdW-1:0]      mark5, space6;
  logic [RUN_COUNT_BITS:0] mark2;
  logic                  bit_taken, bit_one;
  irpr_res_t             pend_res;

  // current sample: a low line means carrier on
  assign sample = ~word_q[0];
  assign trans  = (sample != level_q);

  // run width clipped to the report field
  assign run_ext = {{WidthBits{1'b0}}, run_q};
  assign run_sat = (run_ext > RunExt'(17'h0FFFF)) ? {WidthBits{1'b1}} : run_ext[WidthBits-1:0];

  // mark/space ratio tests as cross products: 5m < 6s and 2m < s
  assign mark5     = (ProdW'(mark_q) << 2) + ProdW'(mark_q);
  assign space6    = (ProdW'(run_q) << 2) + (ProdW'(run_q) << 1);
  assign mark2     = {mark_q, 1'b0};
  assign bit_taken = (mark5 < space6);
  assign bit_one   = (mark2 < {1'b0, run_q});

  // pending run as a result record
  always_comb begin
    pend_res       = '0;
    pend_res.kind  = KIND_RUN;
    pend_res.level = pend_level_q;
    pend_res.width = pend_width_q;
  end

  // next-state logic
  always_comb begin
    word_d       = word_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    mode_d       = mode_q;
    level_d      = level_q;
    run_d        = run_q;
    mark_d       = mark_q;
    code_d       = code_q;
    pend_valid_d = pend_valid_q;
    pend_level_d = pend_level_q;
    pend_width_d = pend_width_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    // output transaction taken
    if (out_take_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      mode_d = cfg_mode_i;
    end

    if (cmd_i.load) begin
      word_d = word_i[SAMPLES_PER_WORD-1:0];
      last_d = last_i;
      cnt_d  = '0;
    end

    // one sample per step
    if (cmd_i.step) begin
      word_d = word_q >> 1;
      cnt_d  = cnt_q + CntBits'(1);
      if (!trans) begin
        if (run_q != {RUN_COUNT_BITS{1'b1}}) begin
          run_d = run_q + RUN_COUNT_BITS'(1);
        end
      end else begin
        if (mode_q == MODE_RUNS) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_res;
          end
          pend_valid_d = 1'b1;
          pend_level_d = level_q;
          pend_width_d = run_sat;
        end
        if (level_q == LEVEL_ON) begin
          mark_d = run_q;
        end else if (bit_taken) begin
          code_d = {code_q[CodeBits-2:0], bit_one};
        end
        run_d   = RUN_COUNT_BITS'(1);
        level_d = ~level_q;
      end
    end

    // trailing run goes through the pending slot
    if (cmd_i.trail) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_res;
      end
      pend_valid_d = 1'b1;
      pend_level_d = level_q;
      pend_width_d = run_sat;
    end

    // decoded frame report
    if (cmd_i.frame) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.kind  = KIND_FRAME;
      out_d.code  = code_q;
      out_d.last  = 1'b1;
    end

    // final run report of the word
    if (cmd_i.flush) begin
      out_valid_d   = 1'b1;
      out_d         = pend_res;
      out_d.last    = 1'b1;
      pend_valid_d  = 1'b0;
    end

    // back to the idle line state after a capture
    if (cmd_i.clear || cmd_i.trail || cmd_i.frame) begin
      level_d = LEVEL_ON;
      run_d   = '0;
      mark_d  = '0;
      code_d  = '0;
    end
  end

  // control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FRAME;
      level_q      <= LEVEL_ON;
      run_q        <= '0;
      mark_q       <= '0;
      code_q       <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      level_q      <= level_d;
      run_q        <= run_d;
      mark_q       <= mark_d;
      code_q       <= code_d;
      cnt_q        <= cnt_d;
      last_q       <= last_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    pend_level_q <= pend_level_d;
    pend_width_q <= pend_width_d;
    out_q        <= out_d;
  end

  // status toward the controller
  always_comb begin
    sts_o             = '0;
    sts_o.mode        = mode_q;
    sts_o.trans       = trans;
    sts_o.pend_valid  = pend_valid_q;
    sts_o.out_busy    = out_valid_q;
    sts_o.last_sample = (cnt_q == CntBits'(SAMPLES_PER_WORD - 1));
    sts_o.last_word   = last_q;
    sts_o.run_one     = (run_q == RUN_COUNT_BITS'(1));
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

FILE: hw/rtl/irpr_ctrl.sv
// irpr_ctrl: sequencer for the ir pulse-ratio decoder
// depends on irpr_pkg; commands irpr_datapath through irpr_cmd_t
module irpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  irpr_pkg::irpr_sts_t sts_i,
  output irpr_pkg::irpr_cmd_t cmd_o
);
  import irpr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_END   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       need_out;

  // a step that closes a run in run mode pushes out the pending report
  assign need_out = sts_i.trans && (sts_i.mode == MODE_RUNS) && sts_i.pend_valid;

  // state transitions and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        if (!need_out || !sts_i.out_busy) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_sample) begin
            state_d = S_END;
          end
        end
      end
      S_END: begin
        if (!sts_i.last_word) begin
          state_d = S_FLUSH;
        end else if (sts_i.mode == MODE_FRAME) begin
          if (!sts_i.out_busy) begin
            cmd_o.frame = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (sts_i.run_one) begin
          cmd_o.clear = 1'b1;
          state_d     = S_FLUSH;
        end else if (!sts_i.pend_valid || !sts_i.out_busy) begin
          cmd_o.trail = 1'b1;
          state_d     = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/ir_pulse_ratio_decoder.sv
// ir_pulse_ratio_decoder: top level of the ir pulse-ratio decoder
// depends on irpr_pkg, irpr_ctrl and irpr_datapath
//
// Decodes an oversampled infrared receiver line that arrives as words of
// SAMPLES_PER_WORD samples, bit 0 first, a low sample meaning carrier on.
// The block measures each mark and space run; when a space ends, a mark to
// space ratio under 1.2 shifts a bit into the code (1 when under 0.5).
// With output_mode 0 the last word of a capture yields one frame report
// (code, command, repeat flag, byte check); with output_mode 1 every run
// is reported except a one-sample run that ends a capture. The decode
// state clears after each last word. A word is loaded, stepped through
// the run counter sample by sample, then closed out in the end and flush
// states (a frame-mode last word sends its frame report from the end
// state and skips the flush). It takes longer when a result is due while
// the output register still holds an untaken result; run reports pass
// through one pending slot ahead of the output register. The next word
// is accepted only after the previous one is done. Config writes are
// always ready and must only happen while the block is idle.
module ir_pulse_ratio_decoder #(
  parameter int SAMPLES_PER_WORD = 32,
  parameter int RUN_COUNT_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i,     // output_mode
  // sample stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_word[31:0]
  input  logic        s_axis_tlast,   // last_word
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // run_level[0], run_width[16:1], raw_code[48:17], command[55:49],
  // repeat_flag[56], check_ok[57], zero fill[63:58]
  output logic [63:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_of_run
);
  import irpr_pkg::*;

  irpr_cmd_t cmd;
  irpr_sts_t sts;
  irpr_res_t res;
  logic      out_valid;
  logic [7:0] code_hi, code_lo;
  logic [8:0] byte_sum;
  logic       check_ok;

  assign cfg_ready_o = 1'b1;

  irpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  irpr_datapath #(
    .SAMPLES_PER_WORD (SAMPLES_PER_WORD),
    .RUN_COUNT_BITS   (RUN_COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .word_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_mode_i  (cfg_data_i[0]),
    .out_take_i  (m_axis_tvalid & m_axis_tready),
    .out_valid_o (out_valid),
    .out_res_o   (res)
  );

  // byte complement check over the low half of the code
  assign code_hi  = res.code[15:8];
  assign code_lo  = res.code[7:0];
  assign byte_sum = {1'b0, code_hi} + {1'b0, code_lo};
  assign check_ok = (byte_sum == 9'd255);

  // result packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, check_ok, code_hi[0], code_hi[7:1], res.code,
                          res.width, res.level};
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;

endmodule
